// ===== src/pdist_pkg.sv =====
package pdist_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_RADIUS = 2'd0;
    localparam logic [1:0] KIND_PAIR   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Configuration register indexes and port widths.
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DIMS    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] COUNT_RESET = 5'd2;
    localparam logic [1:0]       DIMS_RESET  = 2'd3;

    // Classification that the front end attaches to each queued command.
    typedef struct packed {
        logic       reject;
        logic [1:0] dims;
    } cmd_ctl_t;

endpackage

// ===== src/particle_pair_distance_update.sv =====
// Incremental pairwise distance engine.
// Input channel (in_valid/in_ready): one word moves particle particle_index
// to coord_x/y/z (signed Q8.16). Output channel (out_valid/out_ready): the
// squared radius (Q16.16), then the distance (Q9.16) to every other particle
// in ascending index order; last_of_run marks the final word of the run.
// An index at or above particle_count (clamped to 1..MAX_PARTICLES) yields a single rejection word.
// Configuration: cfg_we with cfg_index 0 writes particle_count, 1 writes
// active_dims; write only while the block is idle.
// A rejection passes from the queue through the emit state to the output
// register; the radius is summed over the active dimensions after the store
// write. Each pair distance is then summed and taken through the bit-serial
// square root, so one moved particle occupies the engine for the radius and
// all count - 1 pair distances.
// A two-word queue lets the input side accept words while the engine works.
// Reset clears the position store to zero (per-entry valid bits), sets
// particle_count to 2 and active_dims to 3. When the receiver stalls the
// output word holds and the engine waits; the queue fills and in_ready drops.
module particle_pair_distance_update #(
    parameter int MAX_PARTICLES = 16,
    parameter int MAX_DIMS      = 3,
    parameter int COORD_WIDTH   = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pdist_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pdist_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [$clog2(MAX_PARTICLES)-1:0]       particle_index,
    input  logic signed [COORD_WIDTH-1:0]          coord_x,
    input  logic signed [COORD_WIDTH-1:0]          coord_y,
    input  logic signed [COORD_WIDTH-1:0]          coord_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             result_kind,
    output logic [$clog2(MAX_PARTICLES)-1:0]       partner_index,
    output logic [31:0]                            magnitude,
    output logic                                   last_of_run
);
    import pdist_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int CRD_W = MAX_DIMS * COORD_WIDTH;
    localparam int Q_W   = $bits(cmd_ctl_t) + IDX_W + CNT_W + CRD_W;

    cmd_ctl_t                              front_ctl;
    cmd_ctl_t                              back_ctl;
    logic [CNT_W-1:0]                      count_eff;
    logic [CNT_W-1:0]                      back_count;
    logic [IDX_W-1:0]                      back_index;
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]  coords;
    logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]  back_coords;
    logic                                  push;
    logic                                  pop;
    logic                                  fifo_full;
    logic                                  fifo_empty;
    logic [Q_W-1:0]                        q_wr;
    logic [Q_W-1:0]                        q_rd;

    // Gather the coordinate ports into one array, x first.
    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            case (d)
                0:       coords[d] = coord_x;
                1:       coords[d] = coord_y;
                default: coords[d] = coord_z;
            endcase
        end
    end

    pdist_front #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_DIMS      (MAX_DIMS),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .particle_index (particle_index),
        .fifo_full      (fifo_full),
        .push           (push),
        .ctl            (front_ctl),
        .count_eff      (count_eff)
    );

    assign q_wr = {front_ctl, particle_index, count_eff, coords};
    assign {back_ctl, back_index, back_count, back_coords} = q_rd;

    pdist_fifo #(
        .W (Q_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (q_wr),
        .pop     (pop),
        .rd_data (q_rd),
        .full    (fifo_full),
        .empty   (fifo_empty)
    );

    pdist_back #(
        .MAX_PARTICLES (MAX_PARTICLES),
        .MAX_DIMS      (MAX_DIMS),
        .COORD_WIDTH   (COORD_WIDTH),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_empty    (fifo_empty),
        .pop           (pop),
        .cmd_ctl       (back_ctl),
        .cmd_index     (back_index),
        .cmd_count     (back_count),
        .cmd_coords    (back_coords),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .partner_index (partner_index),
        .magnitude     (magnitude),
        .last_of_run   (last_of_run)
    );

endmodule

// ===== src/pdist_fifo.sv =====
module pdist_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    input  logic         pop,
    output logic [W-1:0] rd_data,
    output logic         full,
    output logic         empty
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // Storage for the queued words.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== src/pdist_front.sv =====
module pdist_front #(
    parameter int MAX_PARTICLES = 16,
    parameter int MAX_DIMS      = 3,
    parameter int IDX_W         = 4,
    parameter int CNT_W         = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pdist_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdist_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [IDX_W-1:0]                    particle_index,
    input  logic                                fifo_full,
    output logic                                push,
    output pdist_pkg::cmd_ctl_t                 ctl,
    output logic [CNT_W-1:0]                    count_eff
);
    import pdist_pkg::*;

    logic [CFG_W-1:0] count_reg;
    logic [1:0]       dims_reg;
    logic [1:0]       dims_eff;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            dims_reg  <= DIMS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PARTICLE_COUNT: count_reg <= cfg_data;
                REG_ACTIVE_DIMS:    dims_reg  <= cfg_data[1:0];
                default:            count_reg <= count_reg;
            endcase
        end
    end

    // Clamp the particle and dimension counts into their legal ranges.
    always_comb
    begin
        if (count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (32'(count_reg) > MAX_PARTICLES)
        begin
            count_eff = CNT_W'(MAX_PARTICLES);
        end
        else
        begin
            count_eff = CNT_W'(count_reg);
        end

        if (dims_reg == 2'd0)
        begin
            dims_eff = 2'd1;
        end
        else if (32'(dims_reg) > MAX_DIMS)
        begin
            dims_eff = 2'(MAX_DIMS);
        end
        else
        begin
            dims_eff = dims_reg;
        end
    end

    // Classify the incoming word and hand it to the queue.
    assign in_ready   = !fifo_full;
    assign push       = in_valid && in_ready;
    assign ctl.reject = (32'(particle_index) >= 32'(count_eff));
    assign ctl.dims   = dims_eff;

endmodule

// ===== src/pdist_sqrt.sv =====
module pdist_sqrt #(
    parameter int RAD_W = 50
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [RAD_W-1:0]     radicand,
    output logic                 done,
    output logic [RAD_W/2-1:0]   root
);

    localparam int STEPS = RAD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    step_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [STEPS+1:0]    rem_reg;
    logic [STEPS-1:0]    root_reg;
    logic [STEPS+3:0]    rem_sh;
    logic [STEPS+3:0]    trial;
    logic                fits;

    // One result bit per cycle, restoring method.
    assign rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial  = (STEPS + 4)'({root_reg, 2'b01});
    assign fits   = (rem_sh >= trial);

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - CNT_W'(1);
                if (step_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (STEPS + 2)'(rem_sh - trial) : (STEPS + 2)'(rem_sh);
            root_reg <= {root_reg[STEPS-2:0], fits};
        end
    end

endmodule

// ===== src/pdist_back.sv =====
module pdist_back #(
    parameter int MAX_PARTICLES = 16,
    parameter int MAX_DIMS      = 3,
    parameter int COORD_WIDTH   = 24,
    parameter int IDX_W         = 4,
    parameter int CNT_W         = 5
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       fifo_empty,
    output logic                                       pop,
    input  pdist_pkg::cmd_ctl_t                        cmd_ctl,
    input  logic [IDX_W-1:0]                           cmd_index,
    input  logic [CNT_W-1:0]                           cmd_count,
    input  logic [MAX_DIMS-1:0][COORD_WIDTH-1:0]       cmd_coords,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [1:0]                                 result_kind,
    output logic [IDX_W-1:0]                           partner_index,
    output logic [31:0]                                magnitude,
    output logic                                       last_of_run
);
    import pdist_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int SQ_W  = 2 * CW + 2;
    localparam int ROOT_W = SQ_W / 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_ACC,
        S_SQRT,
        S_EMIT,
        S_NEXT
    } state_t;

    state_t state_reg;

    // Command being worked on.
    logic [IDX_W-1:0]                   p_reg;
    logic [CNT_W-1:0]                   cnt_reg;
    logic [1:0]                         dims_reg;
    logic [MAX_DIMS-1:0][CW-1:0]        pc_reg;
    logic [CNT_W-1:0]                   i_reg;
    logic [1:0]                         k_reg;
    logic                               radius_reg;
    logic [SQ_W-1:0]                    sq_reg;
    logic [SQ_W-1:0]                    sum_reg;

    // Result waiting for the output register.
    logic [1:0]                         pend_kind_reg;
    logic [IDX_W-1:0]                   pend_partner_reg;
    logic [31:0]                        pend_mag_reg;
    logic                               pend_last_reg;

    // Output register.
    logic                               out_valid_reg;
    logic [1:0]                         kind_reg;
    logic [IDX_W-1:0]                   partner_reg;
    logic [31:0]                        mag_reg;
    logic                               last_reg;

    // Position store.
    logic [MAX_DIMS-1:0][CW-1:0]        store_mem [MAX_PARTICLES];
    logic [MAX_PARTICLES-1:0]           valid_reg;
    logic [MAX_DIMS-1:0][CW-1:0]        rd_reg;
    logic [IDX_W-1:0]                   rd_addr;

    // Datapath signals.
    logic [CW-1:0]                      opa;
    logic [CW-1:0]                      opb;
    logic signed [CW:0]                 diff;
    logic [CW:0]                        absd;
    logic [SQ_W-1:0]                    sq_prod;
    logic [SQ_W-1:0]                    sum_total;
    logic [63:0]                        rad_wide;
    logic [63:0]                        root_wide;
    logic [CNT_W-1:0]                   cand;
    logic [CNT_W:0]                     cand_p1;
    logic [CNT_W:0]                     cand_p2;
    logic [CNT_W:0]                     p_p1;
    logic                               cand_last;
    logic                               sqrt_start;
    logic                               sqrt_done;
    logic [ROOT_W-1:0]                  root;
    logic                               out_load;
    logic                               acc_end;

    // Select the coordinates of the current dimension.
    always_comb
    begin
        opa = '0;
        opb = '0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (32'(k_reg) == d)
            begin
                opa = pc_reg[d];
                opb = radius_reg ? '0 : rd_reg[d];
            end
        end
    end

    // Square of one coordinate difference per cycle; the square is registered, then added to the sum.
    assign diff      = $signed({opa[CW-1], opa}) - $signed({opb[CW-1], opb});
    assign absd      = diff[CW] ? (CW + 1)'(-diff) : (CW + 1)'(diff);
    assign sq_prod   = absd * absd;
    assign sum_total = sum_reg + ((k_reg != 2'd0) ? sq_reg : '0);
    assign acc_end   = (state_reg == S_ACC) && (k_reg == dims_reg);
    assign rad_wide  = 64'(sum_total >> 16);
    assign root_wide = 64'(root);

    // Next partner, skipping the moved particle, and whether it closes the run.
    assign cand      = (i_reg == CNT_W'(p_reg)) ? i_reg + CNT_W'(1) : i_reg;
    assign cand_p1   = (CNT_W + 1)'(cand) + (CNT_W + 1)'(1);
    assign cand_p2   = (CNT_W + 1)'(cand) + (CNT_W + 1)'(2);
    assign p_p1      = (CNT_W + 1)'(p_reg) + (CNT_W + 1)'(1);
    assign cand_last = (cand_p1 == (CNT_W + 1)'(cnt_reg)) ||
                       ((cand_p2 == (CNT_W + 1)'(cnt_reg)) &&
                        (p_p1 == (CNT_W + 1)'(cnt_reg)));
    assign rd_addr   = cand[IDX_W-1:0];

    assign pop        = (state_reg == S_IDLE) && !fifo_empty;
    assign sqrt_start = acc_end && !radius_reg;
    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    pdist_sqrt #(
        .RAD_W (SQ_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_total),
        .done     (sqrt_done),
        .root     (root)
    );

    // Sequencer with its working registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= pend_kind_reg;
                partner_reg   <= pend_partner_reg;
                mag_reg       <= pend_mag_reg;
                last_reg      <= pend_last_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!fifo_empty)
                    begin
                        p_reg    <= cmd_index;
                        cnt_reg  <= cmd_count;
                        dims_reg <= cmd_ctl.dims;
                        pc_reg   <= cmd_coords;
                        if (cmd_ctl.reject)
                        begin
                            pend_kind_reg    <= KIND_REJECT;
                            pend_partner_reg <= '0;
                            pend_mag_reg     <= '0;
                            pend_last_reg    <= 1'b1;
                            state_reg        <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_WRITE:
                begin
                    valid_reg[p_reg] <= 1'b1;
                    radius_reg       <= 1'b1;
                    k_reg            <= 2'd0;
                    sum_reg          <= '0;
                    i_reg            <= '0;
                    state_reg        <= S_ACC;
                end
                S_ACC:
                begin
                    sq_reg  <= sq_prod;
                    sum_reg <= sum_total;
                    k_reg   <= k_reg + 2'd1;
                    if (acc_end)
                    begin
                        if (radius_reg)
                        begin
                            pend_kind_reg    <= KIND_RADIUS;
                            pend_partner_reg <= '0;
                            pend_mag_reg     <= (rad_wide[63:32] != '0) ? '1 : rad_wide[31:0];
                            pend_last_reg    <= (cnt_reg == CNT_W'(1));
                            state_reg        <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_SQRT;
                        end
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        pend_kind_reg <= KIND_PAIR;
                        pend_mag_reg  <= (root_wide[63:32] != '0) ? '1 : root_wide[31:0];
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        state_reg <= pend_last_reg ? S_IDLE : S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    pend_partner_reg <= rd_addr;
                    pend_last_reg    <= cand_last;
                    i_reg            <= cand + CNT_W'(1);
                    radius_reg       <= 1'b0;
                    k_reg            <= 2'd0;
                    sum_reg          <= '0;
                    state_reg        <= S_ACC;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Store write keeps unused dimensions; a never-written entry starts at zero.
    // The partner's position is read once per pair and held while it is summed.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                if (d < 32'(dims_reg))
                begin
                    store_mem[p_reg][d] <= pc_reg[d];
                end
                else if (!valid_reg[p_reg])
                begin
                    store_mem[p_reg][d] <= '0;
                end
            end
        end
        if (state_reg == S_NEXT)
        begin
            rd_reg <= valid_reg[rd_addr] ? store_mem[rd_addr] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign partner_index = partner_reg;
    assign magnitude     = mag_reg;
    assign last_of_run   = last_reg;

    // The root is only picked up while the sequencer waits for it.
    a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == S_SQRT))
        else $error("square root finished outside of its wait state");

    // A rejected index always closes its run.
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (pend_kind_reg == KIND_REJECT)) |-> pend_last_reg)
        else $error("rejection word not marked last");

    // A pair never names the moved particle as its own partner.
    a_partner_not_self: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (pend_kind_reg == KIND_PAIR)) |-> (pend_partner_reg != p_reg))
        else $error("pair distance names the moved particle");

endmodule
